/* hdl/dfam_pkg.sv */
// ----------------------------------------------------------------------------
// dfam_pkg: shared types and constants for the dial forceback axis mapper
// Holds the controller state type, the command/status structs between the
// controller and the datapath, and the fixed constants of the mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package dfam_pkg;

   // field widths
   localparam int POS_W     = 16;
   localparam int MAG_W     = 16;
   localparam int DMAX_W    = 15;
   localparam int CMD_W     = 6;
   localparam int LED_W     = 8;
   localparam int STR_W     = 4;
   localparam int SETTLE_W  = 7;

   // divider geometry
   localparam int DIV_NUM_W    = 30;
   localparam int STICK_STEPS  = 30;
   localparam int LED_STEPS    = 7;
   localparam int STEP_W       = 5;

   // defaults
   localparam int SETTLE_POLLS_DEF = 100;
   localparam logic [DMAX_W-1:0] DIAL_MAX_RESET = 15'd100;

   // mapping constants
   localparam logic [MAG_W:0]    FB_MARGIN    = 17'd4;
   localparam logic [MAG_W-1:0]  SETTLE_ZONE  = 16'd4;
   localparam logic [MAG_W-1:0]  CENTRE_ZONE  = 16'd8;
   localparam logic [DMAX_W-1:0] DEFAULT_MAX  = 15'd100;
   localparam logic [DMAX_W-1:0] CAPTURE_SAT  = 15'h7fff;
   localparam logic [STR_W-1:0]  STRENGTH_CAP = 4'hf;
   localparam logic [CMD_W-1:0]  PUSH_LEFT    = 6'h10;
   localparam logic [CMD_W-1:0]  PUSH_RIGHT   = 6'h20;
   localparam logic [CMD_W-1:0]  MOTOR_OFF    = 6'h00;
   localparam logic [DIV_NUM_W-1:0] AXIS_POS_LIMIT = 30'd32767;
   localparam logic [DIV_NUM_W-1:0] AXIS_NEG_LIMIT = 30'd32768;
   localparam logic [POS_W-1:0]  AXIS_MAX     = 16'h7fff;
   localparam logic [POS_W-1:0]  AXIS_MIN     = 16'h8000;
   localparam logic [LED_W-1:0]  LED_MID      = 8'h80;
   localparam logic [LED_W-1:0]  LED_LOW      = 8'h00;
   localparam logic [LED_W-1:0]  LED_HIGH     = 8'hff;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STICK_LOAD,
      S_STICK_DIV,
      S_LED_LOAD,
      S_LED_DIV,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load_in;
      logic div_load_stick;
      logic div_load_led;
      logic div_step;
      logic save_stick;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic led_skip;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/dfam_divider.sv */
// ----------------------------------------------------------------------------
// dfam_divider: restoring divider, one quotient bit per step
// The remainder starts from a preset value so that a fraction can be
// expanded as well as a plain integer quotient taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dfam_divider (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic                                step,
   input  wire logic [dfam_pkg::DMAX_W-1:0]         rem_init,
   input  wire logic [dfam_pkg::DIV_NUM_W-1:0]      num,
   input  wire logic [dfam_pkg::DMAX_W-1:0]         divisor,
   output logic      [dfam_pkg::DIV_NUM_W-1:0]      quo
);

   logic [dfam_pkg::DMAX_W-1:0]    rem_ff, rem_in;
   logic [dfam_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [dfam_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [dfam_pkg::DMAX_W:0]      rem_shift;
   logic                           fits;

   // shift in the next numerator bit and try a subtract
   always_comb begin
      rem_shift = {rem_ff, num_ff[dfam_pkg::DIV_NUM_W-1]};
      fits      = rem_shift >= {1'b0, divisor};
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      if (load) begin
         rem_in = rem_init;
         num_in = num;
         quo_in = '0;
      end else if (step) begin
         rem_in = fits ? dfam_pkg::DMAX_W'(rem_shift - {1'b0, divisor})
                       : rem_shift[dfam_pkg::DMAX_W-1:0];
         num_in = {num_ff[dfam_pkg::DIV_NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[dfam_pkg::DIV_NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

/* hdl/dfam_datapath.sv */
// ----------------------------------------------------------------------------
// dfam_datapath: dial word registers, divider and result formatting
// Holds the full-scale register, the settle counter and the output word,
// and carries out the steps the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dfam_datapath #(
   parameter int SETTLE_POLLS = dfam_pkg::SETTLE_POLLS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dfam_pkg::dp_cmd_type              cmd,
   output dfam_pkg::dp_status_type                status,
   input  wire logic signed [dfam_pkg::POS_W-1:0] req_dial_pos,
   input  wire logic                              req_setting_flag,
   input  wire logic                              req_calibrate_mode,
   input  wire logic                              req_confirm_pressed,
   input  wire logic                              csr_we,
   input  wire logic [dfam_pkg::DMAX_W-1:0]       csr_data,
   output logic [dfam_pkg::CMD_W-1:0]             rsp_motor_command,
   output logic                                   rsp_command_valid,
   output logic signed [dfam_pkg::POS_W-1:0]      rsp_stick_x,
   output logic [dfam_pkg::LED_W-1:0]             rsp_led_x,
   output logic                                   rsp_capture_valid,
   output logic [dfam_pkg::DMAX_W-1:0]            rsp_captured_max
);

   localparam int CW = dfam_pkg::SETTLE_W;
   localparam logic [CW-1:0] SETTLE_LIMIT = CW'(SETTLE_POLLS);

   localparam int MW = dfam_pkg::MAG_W;
   localparam int DW = dfam_pkg::DMAX_W;
   localparam int NW = dfam_pkg::DIV_NUM_W;

   // configuration and state
   logic [DW-1:0] dial_max_ff;
   logic [CW-1:0] settle_count_ff, settle_count_in;

   // captured dial word
   logic [MW-1:0] mag_ff, mag_in;
   logic          neg_ff, setting_ff, calib_ff, confirm_ff;
   logic [NW-1:0] stick_q_ff;

   // output word
   logic [dfam_pkg::CMD_W-1:0] motor_ff, motor_in;
   logic                       cmd_valid_ff, cmd_valid_in;
   logic [dfam_pkg::POS_W-1:0] stick_ff, stick_in;
   logic [dfam_pkg::LED_W-1:0] led_ff, led_in;
   logic                       cap_valid_ff, cap_valid_in;
   logic [DW-1:0]              cap_max_ff, cap_max_in;

   logic [DW-1:0]  dmax;
   logic [NW:0]    product;
   logic [NW-1:0]  quo;
   logic [MW:0]    excess;
   logic [MW-1:0]  half_excess;
   logic           over_limit;
   logic [dfam_pkg::STR_W-1:0] norm_str, cal_str;
   logic [MW-2:0]  half_mag;
   logic [dfam_pkg::CMD_W-1:0] dir;
   logic [dfam_pkg::LED_W-1:0] led_q;

   // full-scale register; zero acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         dial_max_ff <= dfam_pkg::DIAL_MAX_RESET;
      end else if (csr_we) begin
         dial_max_ff <= csr_data;
      end
   end

   assign dmax = (dial_max_ff == '0) ? DW'(1) : dial_max_ff;

   // capture the dial word as magnitude and sign
   assign mag_in = req_dial_pos[dfam_pkg::POS_W-1] ? MW'(-req_dial_pos)
                                                   : MW'(req_dial_pos);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mag_ff     <= mag_in;
         neg_ff     <= req_dial_pos[dfam_pkg::POS_W-1];
         setting_ff <= req_setting_flag;
         calib_ff   <= req_calibrate_mode;
         confirm_ff <= req_confirm_pressed;
      end
      if (cmd.save_stick) begin
         stick_q_ff <= quo;
      end
   end

   // 32767 * |pos| as a shift and subtract
   assign product = {mag_ff, {DW{1'b0}}} - {{DW{1'b0}}, mag_ff};

   assign status.led_skip = mag_ff >= {1'b0, dmax};

   dfam_divider u_divider (
      .clock    (clock),
      .load     (cmd.div_load_stick | cmd.div_load_led),
      .step     (cmd.div_step),
      .rem_init (cmd.div_load_led ? mag_ff[DW-1:0] : '0),
      .num      (cmd.div_load_led ? '0 : product[NW-1:0]),
      .divisor  (dmax),
      .quo      (quo)
   );

   // forceback strengths and push direction
   assign over_limit  = ({1'b0, mag_ff} + dfam_pkg::FB_MARGIN) > {2'b00, dmax};
   assign excess      = {1'b0, mag_ff} + dfam_pkg::FB_MARGIN - {2'b00, dmax};
   assign half_excess = excess[MW:1];
   assign norm_str    = (half_excess > MW'(dfam_pkg::STRENGTH_CAP))
                        ? dfam_pkg::STRENGTH_CAP : half_excess[dfam_pkg::STR_W-1:0];
   assign half_mag    = mag_ff[MW-1:1];
   assign cal_str     = (half_mag >= (MW-1)'(dfam_pkg::STRENGTH_CAP))
                        ? dfam_pkg::STRENGTH_CAP
                        : dfam_pkg::STR_W'(half_mag[dfam_pkg::STR_W-1:0] + 1'b1);
   assign dir         = neg_ff ? dfam_pkg::PUSH_LEFT : dfam_pkg::PUSH_RIGHT;

   // command, capture and settle counting
   always_comb begin
      motor_in        = dfam_pkg::MOTOR_OFF;
      cmd_valid_in    = 1'b0;
      cap_valid_in    = 1'b0;
      cap_max_in      = '0;
      settle_count_in = settle_count_ff;
      if (!setting_ff) begin
         cmd_valid_in = 1'b1;
         if (over_limit && (norm_str != '0)) begin
            motor_in = dir | {2'b00, norm_str};
         end
      end
      if (calib_ff) begin
         if (settle_count_ff < SETTLE_LIMIT) begin
            cmd_valid_in = 1'b1;
            if (mag_ff > dfam_pkg::SETTLE_ZONE) begin
               settle_count_in = '0;
               motor_in        = dir | {2'b00, cal_str};
            end else begin
               settle_count_in = CW'(settle_count_ff + 1'b1);
               motor_in        = dfam_pkg::MOTOR_OFF;
            end
         end else if (confirm_ff) begin
            cap_valid_in = 1'b1;
            if (mag_ff <= dfam_pkg::CENTRE_ZONE) begin
               cap_max_in = dfam_pkg::DEFAULT_MAX;
            end else if (mag_ff[MW-1]) begin
               cap_max_in = dfam_pkg::CAPTURE_SAT;
            end else begin
               cap_max_in = mag_ff[DW-1:0];
            end
         end
      end else begin
         settle_count_in = '0;
      end
   end

   // saturate the stick axis and center the LED axis
   assign led_q = {1'b0, quo[dfam_pkg::LED_STEPS-1:0]};

   always_comb begin
      if (neg_ff) begin
         stick_in = (stick_q_ff > dfam_pkg::AXIS_NEG_LIMIT) ? dfam_pkg::AXIS_MIN
                    : dfam_pkg::POS_W'(-stick_q_ff[dfam_pkg::POS_W-1:0]);
      end else begin
         stick_in = (stick_q_ff > dfam_pkg::AXIS_POS_LIMIT) ? dfam_pkg::AXIS_MAX
                    : stick_q_ff[dfam_pkg::POS_W-1:0];
      end
      if (status.led_skip) begin
         led_in = neg_ff ? dfam_pkg::LED_LOW : dfam_pkg::LED_HIGH;
      end else begin
         led_in = neg_ff ? dfam_pkg::LED_W'(dfam_pkg::LED_MID - led_q)
                         : dfam_pkg::LED_W'(dfam_pkg::LED_MID + led_q);
      end
   end

   // settle counter
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_count_ff <= '0;
      end else if (cmd.finish) begin
         settle_count_ff <= settle_count_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         motor_ff     <= motor_in;
         cmd_valid_ff <= cmd_valid_in;
         stick_ff     <= stick_in;
         led_ff       <= led_in;
         cap_valid_ff <= cap_valid_in;
         cap_max_ff   <= cap_max_in;
      end
   end

   assign rsp_motor_command = motor_ff;
   assign rsp_command_valid = cmd_valid_ff;
   assign rsp_stick_x       = stick_ff;
   assign rsp_led_x         = led_ff;
   assign rsp_capture_valid = cap_valid_ff;
   assign rsp_captured_max  = cap_max_ff;

`ifndef ASSERT_OFF
   a_settle_bound: assert property (@(posedge clock) disable iff (reset)
      settle_count_ff <= SETTLE_LIMIT)
      else $error("settle count passed its limit");

   a_settle_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !calib_ff |=> settle_count_ff == '0)
      else $error("settle count kept outside calibration");
`endif

endmodule

`default_nettype wire

/* hdl/dfam_controller.sv */
// ----------------------------------------------------------------------------
// dfam_controller: sequencer for one dial word
// Takes a word, runs the stick division and, below full scale, the LED
// fraction on the shared divider, then loads the output register when free.
// ----------------------------------------------------------------------------
`default_nettype none

module dfam_controller (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output dfam_pkg::dp_cmd_type            cmd,
   input  wire dfam_pkg::dp_status_type    status
);

   localparam int SW = dfam_pkg::STEP_W;
   localparam logic [SW-1:0] STICK_LAST = SW'(dfam_pkg::STICK_STEPS - 1);
   localparam logic [SW-1:0] LED_LAST   = SW'(dfam_pkg::LED_STEPS - 1);
   localparam logic [SW-1:0] STICK_CNT  = SW'(dfam_pkg::STICK_STEPS);

   dfam_pkg::ctrl_state_type state_ff, state_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfam_pkg::S_IDLE: begin
            if (req_valid) state_in = dfam_pkg::S_STICK_LOAD;
         end
         dfam_pkg::S_STICK_LOAD: begin
            state_in = dfam_pkg::S_STICK_DIV;
         end
         dfam_pkg::S_STICK_DIV: begin
            if (cnt_ff == STICK_LAST) state_in = dfam_pkg::S_LED_LOAD;
         end
         dfam_pkg::S_LED_LOAD: begin
            state_in = status.led_skip ? dfam_pkg::S_FINISH : dfam_pkg::S_LED_DIV;
         end
         dfam_pkg::S_LED_DIV: begin
            if (cnt_ff == LED_LAST) state_in = dfam_pkg::S_FINISH;
         end
         dfam_pkg::S_FINISH: begin
            if (slot_free) state_in = dfam_pkg::S_IDLE;
         end
         default: state_in = dfam_pkg::S_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         dfam_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         dfam_pkg::S_STICK_LOAD: begin
            cmd.div_load_stick = 1'b1;
            cnt_in             = '0;
         end
         dfam_pkg::S_STICK_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = SW'(cnt_ff + 1'b1);
         end
         dfam_pkg::S_LED_LOAD: begin
            cmd.save_stick   = 1'b1;
            cmd.div_load_led = 1'b1;
            cnt_in           = '0;
         end
         dfam_pkg::S_LED_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = SW'(cnt_ff + 1'b1);
         end
         dfam_pkg::S_FINISH: begin
            cmd.finish = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // hold the result word until taken
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfam_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == dfam_pkg::S_FINISH)
      else $error("result word raised outside finish");

   a_stick_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == dfam_pkg::S_STICK_DIV |-> cnt_ff < STICK_CNT)
      else $error("stick division ran past its step count");

   a_finish_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == dfam_pkg::S_FINISH && !slot_free
      |=> state_ff == dfam_pkg::S_FINISH && rsp_valid_ff)
      else $error("finished word dropped while output was busy");
`endif

endmodule

`default_nettype wire

/* hdl/dial_forceback_axis_mapper.sv */
// Accepts a new word only while idle, so one word is finished and handed
// to the output register before the next is taken; the single shared
// restoring divider runs 30 steps for the stick axis and 7 for the LED
// axis, and the LED steps are skipped when |pos| reaches full scale.
// Reset: synchronous; clears the sequencer, the result valid and the settle
// counter, and sets the full-scale register to 100.
// ----------------------------------------------------------------------------
// dial_forceback_axis_mapper: dial forceback and axis mapping
// Turns one signed dial word into a motor push-back command, a stick axis,
// an LED axis and, in calibration, a captured full-scale value.
// ----------------------------------------------------------------------------
`default_nettype none

module dial_forceback_axis_mapper #(
   parameter int SETTLE_POLLS = dfam_pkg::SETTLE_POLLS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [dfam_pkg::POS_W-1:0] req_dial_pos,
   input  wire logic                              req_setting_flag,
   input  wire logic                              req_calibrate_mode,
   input  wire logic                              req_confirm_pressed,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [dfam_pkg::CMD_W-1:0]             rsp_motor_command,
   output logic                                   rsp_command_valid,
   output logic signed [dfam_pkg::POS_W-1:0]      rsp_stick_x,
   output logic [dfam_pkg::LED_W-1:0]             rsp_led_x,
   output logic                                   rsp_capture_valid,
   output logic [dfam_pkg::DMAX_W-1:0]            rsp_captured_max,
   input  wire logic                              csr_we,
   input  wire logic [dfam_pkg::DMAX_W-1:0]       csr_data
);

   dfam_pkg::dp_cmd_type    cmd;
   dfam_pkg::dp_status_type status;

   dfam_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dfam_datapath #(
      .SETTLE_POLLS (SETTLE_POLLS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_dial_pos        (req_dial_pos),
      .req_setting_flag    (req_setting_flag),
      .req_calibrate_mode  (req_calibrate_mode),
      .req_confirm_pressed (req_confirm_pressed),
      .csr_we              (csr_we),
      .csr_data            (csr_data),
      .rsp_motor_command   (rsp_motor_command),
      .rsp_command_valid   (rsp_command_valid),
      .rsp_stick_x         (rsp_stick_x),
      .rsp_led_x           (rsp_led_x),
      .rsp_capture_valid   (rsp_capture_valid),
      .rsp_captured_max    (rsp_captured_max)
   );

endmodule

`default_nettype wire
